/* rtl/fump_pkg.sv */
// Shared types and constants for the first-unused-match permutation block.
`default_nettype none
package fump_pkg;

    localparam int KEY_W = 64;
    localparam int IDX_W = 6;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_CLEAR  = 2'd0;
    localparam t_mode MODE_APPEND = 2'd1;
    localparam t_mode MODE_MATCH  = 2'd2;
    localparam t_mode MODE_FLUSH  = 2'd3;

    typedef struct packed {
        t_mode              mode;
        logic [KEY_W-1:0]   key;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic               found;
        logic               leftover;
        logic               last;
        logic               overflowed;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_FLUSH
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // latch key, restart scan
        logic clr;      // empty list and used marks
        logic app;      // append key
        logic mstep;    // one match scan step
        logic fstep;    // one flush scan step
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic m_done;
        logic f_done;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

/* rtl/fump_ctrl.sv */
// Controller state machine: sequences clear, append, match and flush beats.
`default_nettype none
module fump_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire fump_pkg::t_mode i_mode,
    input  wire fump_pkg::t_stat i_stat,
    output logic                o_in_stall,
    output fump_pkg::t_cmd      o_cmd
);
    import fump_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    case (i_mode)
                        MODE_CLEAR:  o_cmd.clr = 1'b1;
                        MODE_APPEND: o_cmd.app = 1'b1;
                        MODE_MATCH: begin
                            o_cmd.load = 1'b1;
                            n_state    = S_MATCH;
                        end
                        MODE_FLUSH: begin
                            o_cmd.load = 1'b1;
                            n_state    = S_FLUSH;
                        end
                        default: ;
                    endcase
                end
            end
            S_MATCH: begin
                // advance only when the output register can take a beat
                if (i_stat.out_free) begin
                    o_cmd.mstep = 1'b1;
                    if (i_stat.m_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.fstep = 1'b1;
                    if (i_stat.f_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/fump_dp.sv */
// Datapath: key memory, used marks, scan counter and output register.
`default_nettype none
module fump_dp #(
    parameter int ENTRIES = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire fump_pkg::t_cmd i_cmd,
    input  wire [fump_pkg::KEY_W-1:0] i_key,
    input  wire                 i_out_stall,
    output fump_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    output fump_pkg::t_out      o_out_data
);
    import fump_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [KEY_W-1:0]   mem [ENTRIES];
    logic [KEY_W-1:0]   r_key;
    logic [CW-1:0]      r_idx;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_idx;
    logic [KEY_W-1:0]   r_rd_key;
    logic               r_pend_vld;
    logic [AW-1:0]      r_pend_idx;
    logic [ENTRIES-1:0] r_used;
    logic [CW-1:0]      r_count;
    logic               r_ovf;
    logic               r_out_vld;
    t_out               r_out;
    t_out               n_out;

    logic idx_lt;
    logic idx_end;
    logic hit;
    logic f_unused;
    logic out_free;
    logic out_wr;

    assign idx_lt   = (r_idx < r_count);
    assign idx_end  = !idx_lt;
    assign hit      = r_rd_vld && !r_used[r_rd_idx] && (r_rd_key == r_key);
    assign f_unused = idx_lt && !r_used[r_idx[AW-1:0]];
    assign out_free = !r_out_vld || !i_out_stall;

    assign o_stat.m_done   = hit || (idx_end && !r_rd_vld);
    assign o_stat.f_done   = idx_end;
    assign o_stat.out_free = out_free;

    // Result beat formation.
    always_comb begin
        out_wr           = 1'b0;
        n_out            = r_out;
        n_out.overflowed = r_ovf;
        if (i_cmd.mstep) begin
            if (hit) begin
                out_wr         = 1'b1;
                n_out.index    = IDX_W'(r_rd_idx);
                n_out.found    = 1'b1;
                n_out.leftover = 1'b0;
                n_out.last     = 1'b1;
            end else if (idx_end && !r_rd_vld) begin
                out_wr         = 1'b1;
                n_out.index    = '0;
                n_out.found    = 1'b0;
                n_out.leftover = 1'b0;
                n_out.last     = 1'b1;
            end
        end
        if (i_cmd.fstep) begin
            if (idx_end) begin
                out_wr         = 1'b1;
                n_out.index    = r_pend_vld ? IDX_W'(r_pend_idx) : '0;
                n_out.found    = r_pend_vld;
                n_out.leftover = 1'b1;
                n_out.last     = 1'b1;
            end else if (f_unused && r_pend_vld) begin
                out_wr         = 1'b1;
                n_out.index    = IDX_W'(r_pend_idx);
                n_out.found    = 1'b1;
                n_out.leftover = 1'b1;
                n_out.last     = 1'b0;
            end
        end
    end

    // Key memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.app && (r_count != CW'(ENTRIES))) begin
            mem[r_count[AW-1:0]] <= i_key;
        end
        if (i_cmd.mstep && idx_lt) begin
            r_rd_key <= mem[r_idx[AW-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key;
        end
        if (i_cmd.mstep && idx_lt) begin
            r_rd_idx <= r_idx[AW-1:0];
        end
        if (i_cmd.fstep && f_unused) begin
            r_pend_idx <= r_idx[AW-1:0];
        end
        if (out_wr) begin
            r_out <= n_out;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_used     <= '0;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_count <= '0;
                r_used  <= '0;
            end
            if (i_cmd.app) begin
                if (r_count == CW'(ENTRIES)) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_used[r_count[AW-1:0]] <= 1'b0;
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.load) begin
                r_idx      <= '0;
                r_rd_vld   <= 1'b0;
                r_pend_vld <= 1'b0;
            end
            if (i_cmd.mstep) begin
                r_rd_vld <= idx_lt;
                if (idx_lt) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (hit) begin
                    r_used[r_rd_idx] <= 1'b1;
                end
            end
            if (i_cmd.fstep && idx_lt) begin
                r_idx <= r_idx + CW'(1);
                if (f_unused) begin
                    r_pend_vld <= 1'b1;
                end
            end
            if (out_wr) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

/* rtl/first_unused_match_permutation.sv */
// Top level of the first-unused-match permutation builder.
//
//   channel | dir | handshake                  | payload
//   --------+-----+----------------------------+-------------------------------
//   in      | in  | i_in_valid / o_in_stall    | i_in_data  (mode, key)
//   out     | out | o_out_valid / i_out_stall  | o_out_data (index, found,
//           |     |                            |   leftover, last, overflowed)
//
// Clear and append beats finish in the cycle they are accepted.
// A match scans live entries one per cycle through the key memory read port,
// while the output register is free, ending early on a hit. A flush walks the
// used marks one per cycle, also only while the output register is free.
// Synchronous active-low reset empties the list, clears used marks and overflow;
// no clearing pass over the key memory is needed.
// An output stall freezes the scan; a waiting result does not block accepting
// the next input beat.
`default_nettype none
module first_unused_match_permutation #(
    parameter int ENTRIES = 64
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  wire fump_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    output fump_pkg::t_out  o_out_data
);
    import fump_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequence each accepted beat.
    fump_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_data.mode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Hold keys, used marks and the result register.
    fump_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_key       (i_in_data.key),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // A match result is always the only beat of its item.
    a_match_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.leftover) |-> o_out_data.last)
        else $error("match result without last");

    // An empty result carries index zero and closes its item.
    a_miss_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |->
        (o_out_data.index == '0 && o_out_data.last))
        else $error("not-found result malformed");

    // A match or flush beat accepted makes the block busy next cycle.
    a_busy_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall &&
         (i_in_data.mode == MODE_MATCH || i_in_data.mode == MODE_FLUSH))
        |=> o_in_stall)
        else $error("scan beat did not hold input stall");

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the first-unused-match permutation block.
`default_nettype none
module tb_top;
    import fump_pkg::*;

    localparam int ENTRIES     = 64;
    localparam int STALL_LIMIT = 1000;  // cycles with nothing accepted on either channel
    localparam int TAIL_CYCLES = 80;    // longest match scan plus margin

    // One directed row: the beat to send, and the result typed in by hand
    // where it is obvious (empty list, miss, nothing left to flush).
    typedef struct packed {
        t_mode          mode;
        logic [KEY_W-1:0] key;
        logic           typed;
        t_out           exp;
    } t_row;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    t_in    i_in_data   = '0;
    logic   i_out_stall = 1'b0;
    logic   o_in_stall;
    logic   o_out_valid;
    t_out   o_out_data;

    // Shadow copy of the live list, used marks and sticky overflow flag.
    logic [KEY_W-1:0] live_key [ENTRIES];
    logic [ENTRIES-1:0] used_mark = '0;
    int     live_total = 0;
    logic   ovf_flag   = 1'b0;

    t_out   step_results [$];      // results of the beat just accepted
    t_out   expected_results [$];  // results still owed by the block
    t_row   script [$];

    // Side info that travels with the beat on the input channel.
    logic   beat_typed = 1'b0;
    t_out   beat_exp   = '0;

    logic   in_idle_on  = 1'b1;
    logic   out_idle_on = 1'b1;
    int     stall_left  = 0;
    int     idle_cycles = 0;
    int     beats_sent  = 0;
    int     results_seen = 0;
    int     errors      = 0;
    int     fill        = 0;   // appends since the last clear, as sent
    logic   moved;
    t_out   want;
    t_out   got;

    first_unused_match_permutation #(.ENTRIES(ENTRIES)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_out outcome(int idx, logic found, logic leftover, logic last,
                                     logic ovf);
        t_out r;
        r.index      = IDX_W'(idx);
        r.found      = found;
        r.leftover   = leftover;
        r.last       = last;
        r.overflowed = ovf;
        return r;
    endfunction

    // Append one result to the list of the current beat.
    function automatic void add_result(input t_out r);
        step_results.insert(step_results.size(), r);
    endfunction

    // Append one directed row.
    function automatic void add_row(input t_row r);
        script.insert(script.size(), r);
    endfunction

    // Advance the shadow state by one beat and collect the results it causes.
    function automatic void perm_step(input t_in beat);
        int  n;
        logic hit;
        step_results.delete();
        n   = live_total;
        hit = 1'b0;
        case (beat.mode)
            MODE_CLEAR: begin
                live_total = 0;
                used_mark  = '0;
            end
            MODE_APPEND: begin
                if (n >= ENTRIES) begin
                    ovf_flag = 1'b1;
                end else begin
                    live_key[n]  = beat.key;
                    used_mark[n] = 1'b0;
                    live_total   = n + 1;
                end
            end
            MODE_MATCH: begin
                // Take the lowest unused entry with an equal key.
                for (int i = 0; i < n; i++) begin
                    if (!hit && !used_mark[i] && live_key[i] == beat.key) begin
                        used_mark[i] = 1'b1;
                        hit = 1'b1;
                        add_result(outcome(i, 1'b1, 1'b0, 1'b1, ovf_flag));
                    end
                end
                if (!hit)
                    add_result(outcome(0, 1'b0, 1'b0, 1'b1, ovf_flag));
            end
            MODE_FLUSH: begin
                // List every unused index, ascending; the state stays as is.
                for (int i = 0; i < n; i++) begin
                    if (!used_mark[i])
                        add_result(outcome(i, 1'b1, 1'b1, 1'b0, ovf_flag));
                end
                if (step_results.size() == 0)
                    add_result(outcome(0, 1'b0, 1'b1, 1'b1, ovf_flag));
                else
                    step_results[$].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
        errors++;
        $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what,
                 got_v, want_v);
    endtask

    // Sample both channels at the rising edge. Predict first, then check, so a
    // beat and a result accepted at the same edge are handled in order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                perm_step(i_in_data);
                if (beat_typed)
                    expected_results.insert(expected_results.size(), beat_exp);
                else
                    foreach (step_results[k])
                        expected_results.insert(expected_results.size(), step_results[k]);
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                results_seen++;
                // Hold the next result off for a random stretch.
                stall_left = out_idle_on ? $urandom_range(0, 9) : 0;
                got = o_out_data;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing pending, index",
                                    longint'(got.index), longint'(0));
                end else begin
                    want = expected_results.pop_front();
                    if (got.index !== want.index)
                        report_mismatch("index", longint'(got.index),
                                        longint'(want.index));
                    if (got.found !== want.found)
                        report_mismatch("found", longint'(got.found),
                                        longint'(want.found));
                    if (got.leftover !== want.leftover)
                        report_mismatch("leftover", longint'(got.leftover),
                                        longint'(want.leftover));
                    if (got.last !== want.last)
                        report_mismatch("last", longint'(got.last),
                                        longint'(want.last));
                    if (got.overflowed !== want.overflowed)
                        report_mismatch("overflowed", longint'(got.overflowed),
                                        longint'(want.overflowed));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Drive the receiver stall at the falling edge.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Send one beat: idle for a random gap, then hold valid and payload
    // until the block takes the beat.
    task automatic drive_beat(input t_mode mode, input logic [KEY_W-1:0] key,
                              input logic typed, input t_out exp);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 9) : 0;
        for (int g = 0; g < gap; g++) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_in_data.mode <= mode;
        i_in_data.key  <= key;
        beat_typed = typed;
        beat_exp   = exp;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom(), $urandom()};
    endfunction

    // One well-formed pass: maybe clear, append, match against the stored
    // keys with some misses and noise mixed in, then flush, sometimes twice.
    task automatic run_sequence(input int n_app);
        logic [KEY_W-1:0] pool [4];
        logic [KEY_W-1:0] stored [$];
        logic [KEY_W-1:0] key;
        t_mode mode;
        int n_match;
        in_idle_on  = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
        foreach (pool[p]) pool[p] = random_key();
        // Clear before the list could fill, so overflow stays for the big pass.
        if (fill + n_app > 48 || $urandom_range(0, 5) != 0) begin
            drive_beat(MODE_CLEAR, random_key(), 1'b0, '0);
            fill = 0;
        end
        for (int a = 0; a < n_app; a++) begin
            key = ($urandom_range(0, 2) == 0) ? random_key()
                                              : pool[2'($urandom_range(0, 3))];
            drive_beat(MODE_APPEND, key, 1'b0, '0);
            stored.insert(stored.size(), key);
            fill++;
        end
        n_match = $urandom_range(0, n_app + 2);
        for (int m = 0; m < n_match; m++) begin
            if ($urandom_range(0, 9) == 0) begin
                // Noise: any mode, any key.
                mode = t_mode'($urandom_range(0, 3));
                if (mode == MODE_APPEND)
                    fill++;
                else if (mode == MODE_CLEAR)
                    fill = 0;
                drive_beat(mode, random_key(), 1'b0, '0);
            end else begin
                if ($urandom_range(0, 3) != 0 && stored.size() != 0)
                    key = stored[$urandom_range(0, stored.size() - 1)];
                else
                    key = random_key();
                drive_beat(MODE_MATCH, key, 1'b0, '0);
            end
        end
        drive_beat(MODE_FLUSH, random_key(), 1'b0, '0);
        if ($urandom_range(0, 4) == 0)
            drive_beat(MODE_FLUSH, random_key(), 1'b0, '0);
    endtask

    // End the run if nothing moves on either channel for too long.
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("first_unused_match_permutation verification failed");
        $finish;
    end

    initial begin
        // Directed rows: empty list after reset, both key extremes,
        // duplicates, misses, repeated flush, clear, nothing left.
        add_row(t_row'{MODE_MATCH,  64'h0,                 1'b1,
                       outcome(0, 1'b0, 1'b0, 1'b1, 1'b0)});
        add_row(t_row'{MODE_FLUSH,  64'h0,                 1'b1,
                       outcome(0, 1'b0, 1'b1, 1'b1, 1'b0)});
        add_row(t_row'{MODE_MATCH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                       outcome(0, 1'b0, 1'b0, 1'b1, 1'b0)});
        add_row(t_row'{MODE_APPEND, 64'h0,                 1'b0, '0});
        add_row(t_row'{MODE_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0});
        add_row(t_row'{MODE_APPEND, 64'h5555_5555_5555_5555, 1'b0, '0});
        add_row(t_row'{MODE_APPEND, 64'h0,                 1'b0, '0});
        add_row(t_row'{MODE_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0});
        add_row(t_row'{MODE_MATCH,  64'h0,                 1'b0, '0});
        add_row(t_row'{MODE_MATCH,  64'h0,                 1'b0, '0});
        add_row(t_row'{MODE_MATCH,  64'h0,                 1'b1,
                       outcome(0, 1'b0, 1'b0, 1'b1, 1'b0)});
        add_row(t_row'{MODE_MATCH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0});
        add_row(t_row'{MODE_FLUSH,  64'h0,                 1'b0, '0});
        add_row(t_row'{MODE_FLUSH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0});
        add_row(t_row'{MODE_MATCH,  64'h1,                 1'b1,
                       outcome(0, 1'b0, 1'b0, 1'b1, 1'b0)});
        add_row(t_row'{MODE_CLEAR,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0});
        add_row(t_row'{MODE_FLUSH,  64'h0,                 1'b1,
                       outcome(0, 1'b0, 1'b1, 1'b1, 1'b0)});
        add_row(t_row'{MODE_MATCH,  64'h0,                 1'b1,
                       outcome(0, 1'b0, 1'b0, 1'b1, 1'b0)});
        add_row(t_row'{MODE_APPEND, 64'h8000_0000_0000_0001, 1'b0, '0});
        add_row(t_row'{MODE_MATCH,  64'h8000_0000_0000_0001, 1'b0, '0});
        add_row(t_row'{MODE_FLUSH,  64'h0,                 1'b1,
                       outcome(0, 1'b0, 1'b1, 1'b1, 1'b0)});
        add_row(t_row'{MODE_APPEND, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0, '0});
        add_row(t_row'{MODE_FLUSH,  64'h0,                 1'b0, '0});
        add_row(t_row'{MODE_CLEAR,  64'h0,                 1'b0, '0});

        // Hold reset, then release it at a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r])
            drive_beat(script[r].mode, script[r].key, script[r].typed, script[r].exp);

        // Mostly short lists; now and then a mid-size one.
        while (beats_sent < 150)
            run_sequence(($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 10));
        // Fill the list to the brim and past it: two appends get dropped and
        // the overflow flag sets. Then show it survives a clear.
        run_sequence(ENTRIES + 2);
        run_sequence(3);

        // Drop valid, drain what is owed, then watch for strays.
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        beat_typed = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("first_unused_match_permutation verification clean");
        else
            $display("first_unused_match_permutation verification failed");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/fump_pkg.sv
rtl/fump_ctrl.sv
rtl/fump_dp.sv
rtl/first_unused_match_permutation.sv
bench/tb_top.sv
